@@ sv/polar_follow_velocity_assert.svh @@
// Assertion macros used by the checker of the follow velocity block.
`ifndef POLAR_FOLLOW_VELOCITY_ASSERT_SVH
`define POLAR_FOLLOW_VELOCITY_ASSERT_SVH

// Checked at every clock edge outside reset.
`define PFV_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("pfv assertion failed");

// Checked at every clock edge, reset included.
`define PFV_ASSERT_RST(label, prop) \
  label: assert property (@(posedge clk_i) prop) \
    else $error("pfv reset assertion failed");

`endif

@@ sv/pfv_pkg.sv @@
// Shared widths, codes and the CORDIC cell data type of the follow velocity block.
package pfv_pkg;

  localparam int unsigned XW = 43;
  localparam int unsigned ZW = 34;
  localparam int unsigned GAIN_W = 16;
  localparam int unsigned IN_TDATA_W = 64;
  localparam int unsigned OUT_TDATA_W = 64;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned MAX_STAGES = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_LINEAR_GAIN = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_ANGULAR_GAIN = 1'b1;

  typedef struct packed {
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic signed [ZW-1:0] z;
    logic                 zero;
  } cell_data_t;

endpackage

@@ sv/pfv_prerot.sv @@
// Input stage: scales the offset and rotates left half-plane vectors by pi.
module pfv_prerot (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [31:0]         offset_x_i,
  input  logic [31:0]         offset_y_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output pfv_pkg::cell_data_t out_data_o
);
  import pfv_pkg::*;

  localparam logic signed [ZW-1:0] AngPi = ZW'(64'd3373259426);

  logic       valid_q;
  cell_data_t data_q, data_d;
  logic signed [XW-1:0] xe, ye;

  always_comb begin
    xe = {{(XW-40){offset_x_i[31]}}, offset_x_i, 8'b0};
    ye = {{(XW-40){offset_y_i[31]}}, offset_y_i, 8'b0};
    data_d.zero = (offset_x_i == 32'd0) && (offset_y_i == 32'd0);
    if (offset_x_i[31]) begin
      data_d.x = -xe;
      data_d.y = -ye;
      data_d.z = offset_y_i[31] ? -AngPi : AngPi;
    end else begin
      data_d.x = xe;
      data_d.y = ye;
      data_d.z = '0;
    end
  end

  assign in_ready_o = !valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      data_q <= data_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;
endmodule

@@ sv/pfv_cell.sv @@
// One CORDIC vectoring cell: a fixed shift, a rotation step and one pipeline register.
module pfv_cell #(
  parameter int unsigned IDX = 0
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  pfv_pkg::cell_data_t in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output pfv_pkg::cell_data_t out_data_o
);
  import pfv_pkg::*;

  localparam logic [29:0] AtanTab [MAX_STAGES] = '{
    30'd843314857, 30'd497837829, 30'd263043836, 30'd133525159,
    30'd67021687,  30'd33543516,  30'd16775851,  30'd8388437,
    30'd4194283,   30'd2097149,   30'd1048576,   30'd524288,
    30'd262144,    30'd131072,    30'd65536,     30'd32768,
    30'd16384,     30'd8192,      30'd4096,      30'd2048,
    30'd1024,      30'd512,       30'd256,       30'd128,
    30'd64,        30'd32,        30'd16,        30'd8,
    30'd4,         30'd2,         30'd1,         30'd0
  };
  localparam logic signed [ZW-1:0] Atan = ZW'(AtanTab[IDX]);

  logic       valid_q;
  cell_data_t data_q, data_d;
  logic signed [XW-1:0] xs, ys;

  always_comb begin
    xs = in_data_i.x >>> IDX;
    ys = in_data_i.y >>> IDX;
    data_d.zero = in_data_i.zero;
    if (in_data_i.y > 0) begin
      data_d.x = in_data_i.x + ys;
      data_d.y = in_data_i.y - xs;
      data_d.z = in_data_i.z + Atan;
    end else begin
      data_d.x = in_data_i.x - ys;
      data_d.y = in_data_i.y + xs;
      data_d.z = in_data_i.z - Atan;
    end
  end

  assign in_ready_o = !valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      data_q <= data_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;
endmodule

@@ sv/pfv_post.sv @@
// Output pipeline: gain compensation, gain scaling, rounding, saturation and output register.
module pfv_post (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  pfv_pkg::cell_data_t         in_data_i,
  input  logic [pfv_pkg::GAIN_W-1:0]  linear_gain_i,
  input  logic [pfv_pkg::GAIN_W-1:0]  angular_gain_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [30:0]                 forward_speed_o,
  output logic [31:0]                 turn_rate_o,
  output logic                        saturated_o
);
  import pfv_pkg::*;

  localparam int unsigned MW  = XW - 8;
  localparam int unsigned DPW = MW + 30;
  localparam int unsigned DW  = DPW - 30;
  localparam int unsigned SPW = DW + GAIN_W;
  localparam int unsigned SW  = SPW - 8;
  localparam int unsigned TPW = ZW + GAIN_W + 1;
  localparam logic [29:0] KInv = 30'd652032874;
  localparam logic signed [TPW-1:0] TurnRound = TPW'(64'd2097152);
  localparam logic [DPW-1:0] DistRound = DPW'(64'd536870912);

  logic v1_q, v2_q, v3_q, v4_q, v5_q;
  logic a1, a2, a3, a4, a5;

  logic [MW-1:0]           mag1_q, mag1_d;
  logic signed [TPW-1:0]   tprod1_q, tprod1_d;
  logic signed [ZW-1:0]    zsel;
  logic [XW-1:0]           xsum;
  logic [DPW-1:0]          dprod2_q;
  logic signed [TPW-1:0]   tsum, tfull;
  logic [31:0]             turn2_q, turn2_d, turn3_q, turn4_q;
  logic                    tsat2_q, tsat2_d, tsat3_q, tsat4_q;
  logic [DW-1:0]           dist3_q;
  logic [SPW-1:0]          sprod4_q;
  logic [SW-1:0]           spd;
  logic [30:0]             speed5_q;
  logic [31:0]             turn5_q;
  logic                    sat5_q;

  assign a5 = !v5_q || out_ready_i;
  assign a4 = !v4_q || a5;
  assign a3 = !v3_q || a4;
  assign a2 = !v2_q || a3;
  assign a1 = !v1_q || a2;
  assign in_ready_o = a1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else begin
      if (a1) v1_q <= in_valid_i;
      if (a2) v2_q <= v1_q;
      if (a3) v3_q <= v2_q;
      if (a4) v4_q <= v3_q;
      if (a5) v5_q <= v4_q;
    end
  end

  always_comb begin
    xsum = $unsigned(in_data_i.x) + XW'(128);
    if (in_data_i.zero || in_data_i.x <= 0) begin
      mag1_d = '0;
    end else begin
      mag1_d = MW'(xsum >> 8);
    end
    zsel = in_data_i.zero ? '0 : in_data_i.z;
    tprod1_d = zsel * $signed({1'b0, angular_gain_i});
  end

  always_comb begin
    tsum  = tprod1_q + TurnRound;
    tfull = tsum >>> 22;
    if (tfull[TPW-1:31] == '0 || tfull[TPW-1:31] == '1) begin
      turn2_d = tfull[31:0];
      tsat2_d = 1'b0;
    end else begin
      turn2_d = tfull[TPW-1] ? 32'h8000_0000 : 32'h7FFF_FFFF;
      tsat2_d = 1'b1;
    end
  end

  assign spd = SW'((sprod4_q + SPW'(128)) >> 8);

  always_ff @(posedge clk_i) begin
    if (a1 && in_valid_i) begin
      mag1_q   <= mag1_d;
      tprod1_q <= tprod1_d;
    end
    if (a2 && v1_q) begin
      dprod2_q <= DPW'(mag1_q) * DPW'(KInv);
      turn2_q  <= turn2_d;
      tsat2_q  <= tsat2_d;
    end
    if (a3 && v2_q) begin
      dist3_q <= DW'((dprod2_q + DistRound) >> 30);
      turn3_q <= turn2_q;
      tsat3_q <= tsat2_q;
    end
    if (a4 && v3_q) begin
      sprod4_q <= SPW'(dist3_q) * SPW'(linear_gain_i);
      turn4_q  <= turn3_q;
      tsat4_q  <= tsat3_q;
    end
    if (a5 && v4_q) begin
      if (spd > SW'(32'h7FFF_FFFF)) begin
        speed5_q <= 31'h7FFF_FFFF;
        sat5_q   <= 1'b1;
      end else begin
        speed5_q <= spd[30:0];
        sat5_q   <= tsat4_q;
      end
      turn5_q <= turn4_q;
    end
  end

  assign out_valid_o     = v5_q;
  assign forward_speed_o = speed5_q;
  assign turn_rate_o     = turn5_q;
  assign saturated_o     = sat5_q;
endmodule

@@ sv/polar_follow_velocity.sv @@
// Top level of the follow velocity block: gain registers, CORDIC cell row and output pipeline.
// Each beat on the input carries one target offset and yields exactly one beat on the
// output with forward speed, turn rate and a saturation flag. A new beat is taken every
// cycle unless the output stalls a full pipeline. It has one input stage, one CORDIC
// cell per stage and five stages for gain compensation, scaling and saturation. Every
// stage has its own valid bit and stalls only when the stage after it is full, so
// bubbles close up while the output waits. Gains are written through the config port
// by the user only while no beat is in flight; the block itself does not enforce this.
module polar_follow_velocity #(
  parameter int unsigned CORDIC_STAGES = 16
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [pfv_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [pfv_pkg::GAIN_W-1:0]         cfg_data_i,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // offset_x [31:0], offset_y [63:32]
  input  logic [pfv_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // forward_speed [30:0], turn_rate [62:31], constant 0 [63]
  output logic [pfv_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
  // saturated [0]
  output logic                               m_axis_tuser
);
  import pfv_pkg::*;

  localparam int unsigned NumCells = (CORDIC_STAGES > MAX_STAGES) ? MAX_STAGES : CORDIC_STAGES;

  logic [GAIN_W-1:0] linear_gain_q, angular_gain_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      linear_gain_q  <= GAIN_W'(128);
      angular_gain_q <= GAIN_W'(1024);
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_LINEAR_GAIN:  linear_gain_q  <= cfg_data_i;
        CFG_ANGULAR_GAIN: angular_gain_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  cell_data_t chain_data [NumCells+1];
  logic       chain_valid [NumCells+1];
  logic       chain_ready [NumCells+1];
  logic [30:0] forward_speed;
  logic [31:0] turn_rate;

  pfv_prerot u_prerot (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .offset_x_i  (s_axis_tdata[31:0]),
    .offset_y_i  (s_axis_tdata[63:32]),
    .out_valid_o (chain_valid[0]),
    .out_ready_i (chain_ready[0]),
    .out_data_o  (chain_data[0])
  );

  for (genvar g = 0; g < NumCells; g++) begin : g_cell
    pfv_cell #(
      .IDX (g)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .in_valid_i  (chain_valid[g]),
      .in_ready_o  (chain_ready[g]),
      .in_data_i   (chain_data[g]),
      .out_valid_o (chain_valid[g+1]),
      .out_ready_i (chain_ready[g+1]),
      .out_data_o  (chain_data[g+1])
    );
  end

  pfv_post u_post (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (chain_valid[NumCells]),
    .in_ready_o      (chain_ready[NumCells]),
    .in_data_i       (chain_data[NumCells]),
    .linear_gain_i   (linear_gain_q),
    .angular_gain_i  (angular_gain_q),
    .out_valid_o     (m_axis_tvalid),
    .out_ready_i     (m_axis_tready),
    .forward_speed_o (forward_speed),
    .turn_rate_o     (turn_rate),
    .saturated_o     (m_axis_tuser)
  );

  assign m_axis_tdata = {1'b0, turn_rate, forward_speed};
endmodule

@@ sv/pfv_checker.sv @@
// Port-level checker for the follow velocity block and its bind statement.
`include "polar_follow_velocity_assert.svh"

module pfv_port_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            s_axis_tvalid,
  input logic                            s_axis_tready,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [pfv_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  input logic                            m_axis_tuser
);
  import pfv_pkg::*;

  logic speed_at_cap;
  logic turn_at_limit;
  logic out_stall;

  assign speed_at_cap  = (m_axis_tdata[30:0] == 31'h7FFF_FFFF);
  assign turn_at_limit = (m_axis_tdata[62:31] == 32'h7FFF_FFFF) ||
                         (m_axis_tdata[62:31] == 32'h8000_0000);
  assign out_stall     = m_axis_tvalid && !m_axis_tready;

  `PFV_ASSERT_RST(a_no_beat_in_reset, !rst_ni |-> !m_axis_tvalid)
  `PFV_ASSERT(a_ready_when_out_free, (!m_axis_tvalid || m_axis_tready) |-> s_axis_tready)
  `PFV_ASSERT(a_sat_at_limit, (m_axis_tvalid && m_axis_tuser) |-> (speed_at_cap || turn_at_limit))
  `PFV_ASSERT(a_out_hold, out_stall |=> (m_axis_tvalid && $stable({m_axis_tuser, m_axis_tdata})))
endmodule

bind polar_follow_velocity pfv_port_checker u_pfv_checker (.*);
